FILE: hw/rtl/tkne_pkg.sv
// Shared types and constants for the touch keypad number entry block.
// Has no dependencies; every other file in hw/rtl refers to it by scoped name.
package tkne_pkg;

  // Screen coordinates and the entered number are 10 bits wide.
  localparam int unsigned CoordW = 10;
  localparam int unsigned CoordLimit = 1 << CoordW;
  localparam int unsigned ValueW = 10;
  localparam int unsigned KeyW = 4;

  // Keypad geometry.
  localparam int unsigned GridRows = 5;
  localparam int unsigned GridCols = 3;

  // Appending a digit is allowed only while the value is below this.
  localparam logic [ValueW-1:0] AppendLimit = ValueW'(99);

  // Reset values of the origin registers.
  localparam logic [CoordW-1:0] OriginXReset = CoordW'(0);
  localparam logic [CoordW-1:0] OriginYReset = CoordW'(170);

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegOriginX = 1'b0;
  localparam logic [CfgIdxW-1:0] RegOriginY = 1'b1;

  // Key codes.
  localparam logic [KeyW-1:0] KeyNone     = 4'd0;
  localparam logic [KeyW-1:0] KeyCancel   = 4'd1;
  localparam logic [KeyW-1:0] KeySep      = 4'd2;
  localparam logic [KeyW-1:0] KeyAlt      = 4'd3;
  localparam logic [KeyW-1:0] KeyDigitLo  = 4'd4;
  localparam logic [KeyW-1:0] KeyDigitHi  = 4'd12;
  localparam logic [KeyW-1:0] KeyDelete   = 4'd13;
  localparam logic [KeyW-1:0] KeyZero     = 4'd14;
  localparam logic [KeyW-1:0] KeyEnter    = 4'd15;
  // Digit keys start at digit 1, so the digit is the key minus this.
  localparam logic [KeyW-1:0] KeyDigitBias = 4'd3;

  // How an entry finished.
  typedef enum logic [1:0] {
    OutcomeNumber    = 2'd0,
    OutcomeCancelled = 2'd1,
    OutcomeAlternate = 2'd2
  } outcome_e;

  // One touch sample.
  typedef struct packed {
    logic              touch_pressed;
    logic [CoordW-1:0] touch_x;
    logic [CoordW-1:0] touch_y;
  } touch_t;

  // One result beat.
  typedef struct packed {
    logic [KeyW-1:0]   new_key;
    logic [ValueW-1:0] entry_value;
    logic              entry_done;
    outcome_e          entry_outcome;
  } entry_t;

endpackage

FILE: hw/rtl/touch_keypad_number_entry.sv
// Touch keypad number entry: hit test and decimal entry on touch samples.
// An accepted sample passes through the input register, then through the hit
// test and entry update into the result register, which holds its result beat.
// Throughput is one sample per cycle while the output is not stalled.
// Reset clears the held key, the number, both valid flags and sets the
// origin registers to x 0, y 170. Depends on tkne_pkg, tkne_hit, tkne_entry.
module touch_keypad_number_entry #(
  parameter int unsigned CellWidth  = 80,
  parameter int unsigned CellHeight = 30
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  tkne_pkg::touch_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tkne_pkg::entry_t             out_data_o,
  input  logic                         cfg_we_i,
  input  logic [tkne_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tkne_pkg::CoordW-1:0]  cfg_wdata_i
);

  logic [tkne_pkg::CoordW-1:0] origin_x_q;
  logic [tkne_pkg::CoordW-1:0] origin_y_q;
  tkne_pkg::touch_t            in_q;
  logic                        in_valid_q;
  tkne_pkg::entry_t            out_q;
  logic                        out_valid_q;
  logic                        out_free;
  logic                        step;
  logic                        in_free;
  logic [tkne_pkg::KeyW-1:0]   hit;
  tkne_pkg::entry_t            result;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= tkne_pkg::OriginXReset;
      origin_y_q <= tkne_pkg::OriginYReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tkne_pkg::RegOriginX: origin_x_q <= cfg_wdata_i;
        tkne_pkg::RegOriginY: origin_y_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Handshake: the result register frees when its beat is taken, and the
  // input register frees when its sample moves on.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_free    = !in_valid_q || step;
  assign in_stall_o = !in_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  tkne_hit #(
    .CellWidth (CellWidth),
    .CellHeight(CellHeight)
  ) u_hit (
    .origin_x_i(origin_x_q),
    .origin_y_i(origin_y_q),
    .touch_x_i (in_q.touch_x),
    .touch_y_i (in_q.touch_y),
    .key_o     (hit)
  );

  tkne_entry u_entry (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .pressed_i(in_q.touch_pressed),
    .hit_i    (hit),
    .result_o (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/tkne_hit.sv
// Hit test of one touch point against the keypad grid.
// Depends on tkne_pkg for the coordinate width, grid size and key width.
module tkne_hit #(
  parameter int unsigned CellWidth  = 80,
  parameter int unsigned CellHeight = 30
) (
  input  logic [tkne_pkg::CoordW-1:0] origin_x_i,
  input  logic [tkne_pkg::CoordW-1:0] origin_y_i,
  input  logic [tkne_pkg::CoordW-1:0] touch_x_i,
  input  logic [tkne_pkg::CoordW-1:0] touch_y_i,
  output logic [tkne_pkg::KeyW-1:0]   key_o
);

  // Wide enough for the far edge of the grid without wrapping.
  localparam int unsigned SpanX = tkne_pkg::CoordLimit + tkne_pkg::GridCols * CellWidth;
  localparam int unsigned SpanY = tkne_pkg::CoordLimit + tkne_pkg::GridRows * CellHeight;
  localparam int unsigned SumW  = (SpanX > SpanY) ? $clog2(SpanX) : $clog2(SpanY);

  logic [SumW-1:0] px;
  logic [SumW-1:0] py;
  logic [tkne_pkg::GridRows-1:0] row_hit;
  logic [tkne_pkg::GridCols-1:0] col_hit;

  assign px = SumW'(touch_x_i);
  assign py = SumW'(touch_y_i);

  // Each row and column band is tested strictly inside its edges.
  always_comb begin
    logic [SumW-1:0] top;
    logic [SumW-1:0] left;
    for (int r = 0; r < tkne_pkg::GridRows; r++) begin
      top = SumW'(origin_y_i) + SumW'(r * CellHeight);
      row_hit[r] = (py > top) && (py < top + SumW'(CellHeight));
    end
    for (int c = 0; c < tkne_pkg::GridCols; c++) begin
      left = SumW'(origin_x_i) + SumW'(c * CellWidth);
      col_hit[c] = (px > left) && (px < left + SumW'(CellWidth));
    end
  end

  // The first match in row-major order wins; walking backward leaves it last.
  always_comb begin
    key_o = tkne_pkg::KeyNone;
    for (int r = tkne_pkg::GridRows - 1; r >= 0; r--) begin
      for (int c = tkne_pkg::GridCols - 1; c >= 0; c--) begin
        if (row_hit[r] && col_hit[c]) begin
          key_o = tkne_pkg::KeyW'(r * tkne_pkg::GridCols + c + 1);
        end
      end
    end
  end

endmodule

FILE: hw/rtl/tkne_entry.sv
// Press tracking and decimal entry state, with the result of one sample.
// Depends on tkne_pkg for key codes, the outcome type and the result struct.
module tkne_entry (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      pressed_i,
  input  logic [tkne_pkg::KeyW-1:0] hit_i,
  output tkne_pkg::entry_t          result_o
);

  logic [tkne_pkg::KeyW-1:0]    held_key_q, held_key_d;
  logic [tkne_pkg::ValueW-1:0]  acc_q, acc_d;
  logic [tkne_pkg::KeyW-1:0]    key;
  logic [tkne_pkg::ValueW-1:0]  acc_upd;
  logic [tkne_pkg::ValueW-1:0]  acc_x10;
  logic [tkne_pkg::ValueW-1:0]  acc_div10;
  logic [tkne_pkg::ValueW+10:0] div_prod;
  logic [tkne_pkg::ValueW-1:0]  digit;
  logic                         can_append;

  // A key is reported once per press; release forgets the held key.
  always_comb begin
    key = tkne_pkg::KeyNone;
    held_key_d = held_key_q;
    if (!pressed_i) begin
      held_key_d = tkne_pkg::KeyNone;
    end else if (hit_i != tkne_pkg::KeyNone) begin
      held_key_d = hit_i;
      if (hit_i != held_key_q) begin
        key = hit_i;
      end
    end
  end

  // Times ten as shifts; divide by ten through the reciprocal 205/2048,
  // exact for every value the entry can hold.
  assign acc_x10    = (acc_q << 3) + (acc_q << 1);
  assign div_prod   = (tkne_pkg::ValueW + 11)'(acc_q) * (tkne_pkg::ValueW + 11)'(205);
  assign acc_div10  = div_prod[tkne_pkg::ValueW+10:11];
  assign digit      = tkne_pkg::ValueW'(key - tkne_pkg::KeyDigitBias);
  assign can_append = acc_q < tkne_pkg::AppendLimit;

  // Apply the key to the entry and form the result beat.
  always_comb begin
    acc_upd = acc_q;
    result_o.new_key = key;
    result_o.entry_done = 1'b0;
    result_o.entry_outcome = tkne_pkg::OutcomeNumber;
    case (key) inside
      tkne_pkg::KeyCancel: begin
        acc_upd = '0;
        result_o.entry_done = 1'b1;
        result_o.entry_outcome = tkne_pkg::OutcomeCancelled;
      end
      tkne_pkg::KeyAlt: begin
        acc_upd = '0;
        result_o.entry_done = 1'b1;
        result_o.entry_outcome = tkne_pkg::OutcomeAlternate;
      end
      [tkne_pkg::KeyDigitLo:tkne_pkg::KeyDigitHi]: begin
        if (can_append) begin
          acc_upd = acc_x10 + digit;
        end
      end
      tkne_pkg::KeyDelete: begin
        acc_upd = acc_div10;
      end
      tkne_pkg::KeyZero: begin
        if (can_append) begin
          acc_upd = acc_x10;
        end
      end
      tkne_pkg::KeyEnter: begin
        result_o.entry_done = 1'b1;
      end
      default: begin
      end
    endcase
    result_o.entry_value = acc_upd;
    acc_d = (key == tkne_pkg::KeyEnter) ? '0 : acc_upd;
  end

  // State moves only when the sample is handed to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_key_q <= tkne_pkg::KeyNone;
      acc_q <= '0;
    end else if (step_i) begin
      held_key_q <= held_key_d;
      acc_q <= acc_d;
    end
  end

endmodule

FILE: tb/touch_keypad_number_entry_tb.sv
// Self-checking testbench for the touch keypad number entry block.
// It sends touch samples with random gaps and output stalls, predicts every result beat
// and compares it field by field. Depends on tkne_pkg and touch_keypad_number_entry.
module touch_keypad_number_entry_tb;

  localparam int unsigned CellW = 80;
  localparam int unsigned CellH = 30;
  localparam int unsigned MaxCoord = tkne_pkg::CoordLimit - 1;
  localparam int unsigned StallLimit = 1000;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  tkne_pkg::touch_t             in_data_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  tkne_pkg::entry_t             out_data_o;
  logic                         cfg_we_i;
  logic [tkne_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [tkne_pkg::CoordW-1:0]  cfg_wdata_i;

  // Predicted state of the block.
  logic [tkne_pkg::CoordW-1:0] grid_x;
  logic [tkne_pkg::CoordW-1:0] grid_y;
  logic [tkne_pkg::KeyW-1:0]   held_key;
  int unsigned                 entry_number;

  tkne_pkg::entry_t pending_entries[$];
  int unsigned      mismatch_count;
  int unsigned      quiet_cycles;
  int unsigned      last_key;
  int unsigned      stall_left;
  bit               calm;
  bit               sending;

  touch_keypad_number_entry #(
    .CellWidth (CellW),
    .CellHeight(CellH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hit test: a point counts only strictly inside a cell, first match in row-major order.
  function automatic logic [tkne_pkg::KeyW-1:0] find_key(input int px, input int py);
    int top;
    int left;
    int idx;
    for (int r = 0; r < tkne_pkg::GridRows; r++) begin
      top = grid_y + r * CellH;
      if (py > top && py < top + CellH) begin
        for (int c = 0; c < tkne_pkg::GridCols; c++) begin
          left = grid_x + c * CellW;
          if (px > left && px < left + CellW) begin
            idx = r * tkne_pkg::GridCols + c + 1;
            return idx[tkne_pkg::KeyW-1:0];
          end
        end
      end
    end
    return tkne_pkg::KeyNone;
  endfunction

  // Works out the result beat of one sample and advances the predicted state.
  function automatic tkne_pkg::entry_t predict_entry(input tkne_pkg::touch_t s);
    tkne_pkg::entry_t          e;
    logic [tkne_pkg::KeyW-1:0] hit;
    e = '0;
    e.new_key = tkne_pkg::KeyNone;
    e.entry_outcome = tkne_pkg::OutcomeNumber;
    if (s.touch_pressed) begin
      hit = find_key(s.touch_x, s.touch_y);
      if (hit != tkne_pkg::KeyNone && hit != held_key) begin
        e.new_key = hit;
        held_key = hit;
      end
    end else begin
      held_key = tkne_pkg::KeyNone;
    end

    if (e.new_key == tkne_pkg::KeyCancel) begin
      e.entry_done = 1'b1;
      e.entry_outcome = tkne_pkg::OutcomeCancelled;
      entry_number = 0;
    end else if (e.new_key == tkne_pkg::KeyAlt) begin
      e.entry_done = 1'b1;
      e.entry_outcome = tkne_pkg::OutcomeAlternate;
      entry_number = 0;
    end else if (e.new_key >= tkne_pkg::KeyDigitLo && e.new_key <= tkne_pkg::KeyDigitHi) begin
      if (entry_number < tkne_pkg::AppendLimit) begin
        entry_number = entry_number * 10 + (e.new_key - tkne_pkg::KeyDigitBias);
      end
    end else if (e.new_key == tkne_pkg::KeyDelete) begin
      entry_number = entry_number / 10;
    end else if (e.new_key == tkne_pkg::KeyZero) begin
      if (entry_number < tkne_pkg::AppendLimit) begin
        entry_number = entry_number * 10;
      end
    end

    e.entry_value = entry_number[tkne_pkg::ValueW-1:0];
    // Enter reports the number before it is cleared.
    if (e.new_key == tkne_pkg::KeyEnter) begin
      e.entry_done = 1'b1;
      e.entry_outcome = tkne_pkg::OutcomeNumber;
      entry_number = 0;
    end
    return e;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Digits dominate so that the number often reaches the append limit.
  function automatic int unsigned pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(tkne_pkg::KeyDigitLo, tkne_pkg::KeyDigitHi);
    if (r < 65) return tkne_pkg::KeyZero;
    if (r < 77) return tkne_pkg::KeyDelete;
    if (r < 87) return tkne_pkg::KeyEnter;
    if (r < 92) return tkne_pkg::KeyCancel;
    if (r < 96) return tkne_pkg::KeyAlt;
    return tkne_pkg::KeySep;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Compares one accepted result beat with the oldest prediction.
  task automatic check_entry(input tkne_pkg::entry_t got);
    tkne_pkg::entry_t want;
    if (pending_entries.size() == 0) begin
      report_mismatch($sformatf("result beat with no prediction pending, key %0d",
                                got.new_key));
      return;
    end
    want = pending_entries.pop_front();
    if (got.new_key !== want.new_key)
      report_mismatch($sformatf("new_key got %0d want %0d", got.new_key, want.new_key));
    if (got.entry_value !== want.entry_value)
      report_mismatch($sformatf("entry_value got %0d want %0d",
                                got.entry_value, want.entry_value));
    if (got.entry_done !== want.entry_done)
      report_mismatch($sformatf("entry_done got %0d want %0d",
                                got.entry_done, want.entry_done));
    if (got.entry_outcome !== want.entry_outcome)
      report_mismatch($sformatf("entry_outcome got %0d want %0d",
                                got.entry_outcome, want.entry_outcome));
  endtask

  // Lowers valid once, only if it is being held high.
  task automatic hold_input();
    if (sending) begin
      in_valid_i <= 1'b0;
      sending = 1'b0;
    end
  endtask

  // Sends one sample after an optional gap and predicts its result on acceptance.
  task automatic send_touch(input logic pressed, input int x, input int y);
    tkne_pkg::touch_t s;
    int unsigned      gap;
    s.touch_pressed = pressed;
    s.touch_x = x[tkne_pkg::CoordW-1:0];
    s.touch_y = y[tkne_pkg::CoordW-1:0];
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      hold_input();
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= s;
    sending = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_entries.push_back(predict_entry(s));
  endtask

  // Touches a random point strictly inside the cell of the given key.
  task automatic press_key(input int unsigned key);
    int unsigned row;
    int unsigned col;
    row = (key - 1) / tkne_pkg::GridCols;
    col = (key - 1) % tkne_pkg::GridCols;
    last_key = key;
    send_touch(1'b1, grid_x + col * CellW + $urandom_range(1, CellW - 1),
               grid_y + row * CellH + $urandom_range(1, CellH - 1));
  endtask

  // Stops sending and waits until every predicted beat has arrived.
  task automatic drain();
    hold_input();
    wait (pending_entries.size() == 0);
    @(posedge clk_i);
  endtask

  // Moves the grid origin; both registers are written back to back while idle.
  task automatic config_pad(input int unsigned x, input int unsigned y);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= tkne_pkg::RegOriginX;
    cfg_wdata_i <= x[tkne_pkg::CoordW-1:0];
    @(posedge clk_i);
    cfg_idx_i <= tkne_pkg::RegOriginY;
    cfg_wdata_i <= y[tkne_pkg::CoordW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grid_x = x[tkne_pkg::CoordW-1:0];
    grid_y = y[tkne_pkg::CoordW-1:0];
  endtask

  // Corners of the coordinate space with a press, and two of them also without.
  task automatic test_field_extremes();
    send_touch(1'b0, 0, 0);
    send_touch(1'b1, 0, 0);
    send_touch(1'b1, MaxCoord, MaxCoord);
    send_touch(1'b0, MaxCoord, MaxCoord);
    send_touch(1'b1, MaxCoord, 0);
    send_touch(1'b1, 0, MaxCoord);
  endtask

  // Every key action: digits, zero, the append limit, delete, separator and the finishes.
  task automatic test_key_actions();
    press_key(tkne_pkg::KeyDigitLo);
    press_key(tkne_pkg::KeyDigitLo);
    send_touch(1'b0, 0, 0);
    press_key(tkne_pkg::KeyZero);
    press_key(tkne_pkg::KeyDigitHi);
    press_key(tkne_pkg::KeyDigitLo + 1);
    press_key(tkne_pkg::KeyDelete);
    press_key(tkne_pkg::KeySep);
    press_key(tkne_pkg::KeyEnter);
    press_key(tkne_pkg::KeyDigitLo + 2);
    press_key(tkne_pkg::KeyCancel);
    press_key(tkne_pkg::KeyDigitLo + 3);
    press_key(tkne_pkg::KeyAlt);
  endtask

  // A press outside the grid or on a cell border keeps the held key.
  task automatic test_held_and_edges();
    press_key(tkne_pkg::KeyDigitLo + 4);
    send_touch(1'b1, 500, 500);
    press_key(tkne_pkg::KeyDigitLo + 4);
    send_touch(1'b1, grid_x + 2 * CellW, grid_y + 2 * CellH + CellH / 2);
    send_touch(1'b0, grid_x + 2 * CellW, grid_y + 2 * CellH + CellH / 2);
  endtask

  // Origins at the far screen edge leave cells unreachable; the zero origin has a
  // border on the screen edge.
  task automatic test_grid_origins();
    config_pad(1000, 1000);
    send_touch(1'b1, 1010, 1010);
    send_touch(1'b1, MaxCoord, MaxCoord);
    config_pad(MaxCoord, MaxCoord);
    send_touch(1'b1, MaxCoord, MaxCoord);
    config_pad(0, 0);
    send_touch(1'b0, 1, 1);
    send_touch(1'b1, 1, 1);
    send_touch(1'b1, 0, CellH / 2);
  endtask

  // One origin setting: mostly key presses, some holds, releases, borders and noise.
  task automatic run_phase(input int unsigned x, input int unsigned y,
                           input int unsigned count);
    int unsigned r;
    config_pad(x, y);
    for (int unsigned n = 0; n < count; n++) begin
      // A stretch without idling on either side in the middle of the phase.
      calm = (n >= count / 2 && n < count / 2 + count / 5);
      if (n == count / 3) drain();
      r = $urandom_range(0, 99);
      if (r < 60) begin
        press_key(pick_key());
      end else if (r < 70) begin
        press_key(last_key);
      end else if (r < 80) begin
        send_touch(1'b0, $urandom_range(0, MaxCoord), $urandom_range(0, MaxCoord));
      end else if (r < 84) begin
        send_touch(1'b1, grid_x + $urandom_range(0, tkne_pkg::GridCols) * CellW,
                   grid_y + $urandom_range(0, tkne_pkg::GridRows * CellH));
      end else if (r < 88) begin
        send_touch(1'b1, grid_x + $urandom_range(0, tkne_pkg::GridCols * CellW),
                   grid_y + $urandom_range(0, tkne_pkg::GridRows) * CellH);
      end else begin
        send_touch(1'($urandom_range(0, 1)), $urandom_range(0, MaxCoord),
                   $urandom_range(0, MaxCoord));
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_random_entry();
    run_phase(0, 0, 300);
    run_phase($urandom_range(0, MaxCoord - tkne_pkg::GridCols * CellW),
              $urandom_range(0, MaxCoord - tkne_pkg::GridRows * CellH), 300);
    run_phase($urandom_range(0, MaxCoord - tkne_pkg::GridCols * CellW),
              $urandom_range(0, MaxCoord - tkne_pkg::GridRows * CellH), 300);
    run_phase(MaxCoord - tkne_pkg::GridCols * CellW,
              MaxCoord - tkne_pkg::GridRows * CellH, 300);
    run_phase(tkne_pkg::OriginXReset, tkne_pkg::OriginYReset, 300);
  endtask

  // Output stall: random bursts, none while calm.
  initial begin
    out_stall_i <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (calm) begin
        stall_left = 0;
      end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result checking and the count of cycles without any accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (out_valid_o && !out_stall_i) check_entry(out_data_o);
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= tkne_pkg::RegOriginX;
    cfg_wdata_i <= '0;
    grid_x = tkne_pkg::OriginXReset;
    grid_y = tkne_pkg::OriginYReset;
    held_key = tkne_pkg::KeyNone;
    entry_number = 0;
    last_key = tkne_pkg::KeyDigitLo;
    mismatch_count = 0;
    quiet_cycles = 0;
    calm = 1'b0;
    sending = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_field_extremes();
    test_key_actions();
    test_held_and_edges();
    test_grid_origins();
    test_random_entry();

    // Wait for the last beats, then keep the clock running to catch any extra one.
    hold_input();
    wait (pending_entries.size() == 0);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_entries.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
